// ===== hw/rtl/eopu_pkg.sv =====
// Shared types, constants and tables for the odometry pose update unit.
package eopu_pkg;

	localparam logic signed [35:0] Q28_TWO_PI  = 36'sd1686629713;
	localparam logic signed [35:0] Q28_PI      = 36'sd843314857;
	localparam logic signed [35:0] Q28_HALF_PI = 36'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
	localparam logic signed [33:0] DIST_LIMIT  = 34'sd4294967295;

	localparam logic [1:0] REG_DIST_PER_COUNT = 2'd0;
	localparam logic [1:0] REG_LEFT_GAIN      = 2'd1;
	localparam logic [1:0] REG_RIGHT_GAIN     = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LG,
		ST_MUL_RG,
		ST_MUL_DL,
		ST_MUL_DLH,
		ST_MUL_DR,
		ST_MUL_DRH,
		ST_REDUCE,
		ST_CORDIC,
		ST_MUL_LC,
		ST_MUL_RS,
		ST_MUL_LS,
		ST_MUL_RC,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} cordic_ctl_t;

	function automatic logic [27:0] atan_q28(input logic [4:0] i);
		logic [27:0] r;
		unique case (i)
			5'd0: r = 28'd210828714;
			5'd1: r = 28'd124459457;
			5'd2: r = 28'd65760959;
			5'd3: r = 28'd33381290;
			5'd4: r = 28'd16755422;
			5'd5: r = 28'd8385879;
			5'd6: r = 28'd4193963;
			5'd7: r = 28'd2097109;
			5'd8: r = 28'd1048571;
			5'd9: r = 28'd524287;
			5'd29, 5'd30, 5'd31: r = 28'd0;
			default: r = 28'd1 << (5'd28 - i);
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/eopu_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module eopu_cordic #(
	parameter int STEPS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [35:0]         angle,
	input  logic                       flip,
	output eopu_pkg::cordic_ctl_t      ctl,
	output logic signed [33:0]         cos_out,
	output logic signed [33:0]         sin_out
);
	import eopu_pkg::*;

	localparam int CW = $clog2(STEPS + 1);

	logic signed [35:0] x_q, y_q, z_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q, flip_q;
	logic [4:0]         idx;
	logic signed [35:0] xs, ys, xf, yf;

	assign idx = 5'(cnt_q);
	assign xs  = x_q >>> idx;
	assign ys  = y_q >>> idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q == CW'(STEPS - 1))
				busy_q <= 1'b0;
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 36'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= angle;
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[35]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - 36'(atan_q28(idx));
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + 36'(atan_q28(idx));
			end
		end
	end

	always_comb begin
		xf = flip_q ? -x_q : x_q;
		yf = flip_q ? -y_q : y_q;
		cos_out = (xf > 36'(Q30_ONE)) ? Q30_ONE :
			(xf < -36'(Q30_ONE)) ? -Q30_ONE : 34'(xf);
		sin_out = (yf > 36'(Q30_ONE)) ? Q30_ONE :
			(yf < -36'(Q30_ONE)) ? -Q30_ONE : 34'(yf);
	end

	assign ctl.start = start;
	assign ctl.busy  = busy_q;
endmodule

// ===== hw/rtl/encoder_odometry_pose_update_unit.sv =====
// Top level: sequencer, shared multiplier and pose accumulators.
//  channel | dir | tdata fields (low bit first)
//  s_axis  | in  | left_count[15:0], right_count[31:16]
//  m_axis  | out | x_out[31:0], y_out[63:32], heading_out[95:64]
//  cfg     | in  | cfg_we, cfg_index, cfg_data
// Each item is worked through in turn: the heading and distance products, the CORDIC
// loop, the rotation products and the pose update, and the result is then offered.
// The single 34x34 multiplier is used in ten products.
// s_tready is high only while idle; the result register holds until taken.
// Reset clears pose, previous counts and registers to zero.
module encoder_odometry_pose_update_unit #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // left_count, right_count
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata    // x_out, y_out, heading_out
);
	import eopu_pkg::*;

	localparam logic [38:0] TP_U  = 39'd1686629713;
	localparam logic [38:0] PI_U  = 39'd843314857;
	localparam logic [38:0] OFF_U = TP_U << 5;

	state_t state_q, state_d;
	logic [31:0] dpc_q, lg_q, rg_q;
	logic [15:0] prev_l_q, prev_r_q;
	logic signed [31:0] x_q, y_q, th_q;
	logic signed [16:0] dlc_q, drc_q;
	logic signed [47:0] fl_q, fr_q;
	logic signed [63:0] dl_q, dr_q, acc_q, dy_q;
	logic signed [33:0] dl16_q, dr16_q, s_q, c_q;
	logic signed [35:0] z_q;
	logic [38:0] zm_q;
	logic flip_q;
	logic signed [33:0] ma, mb;
	logic signed [67:0] prod;
	logic cstart;
	cordic_ctl_t cctl;
	logic signed [33:0] cos_w, sin_w;
	logic signed [35:0] zr;
	logic signed [47:0] t_fl;

	assign prod = ma * mb;

	function automatic logic signed [33:0] clampd(input logic signed [63:0] v);
		logic signed [63:0] f;
		f = v >>> 16;
		if (f > 64'(DIST_LIMIT)) return DIST_LIMIT;
		if (f < -64'(DIST_LIMIT)) return -DIST_LIMIT;
		return 34'(f);
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return 32'(v);
	endfunction

	function automatic logic [38:0] mod_sub(input logic [38:0] v, input logic [38:0] m);
		return (v >= m) ? v - m : v;
	endfunction

	eopu_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cstart), .angle(z_q), .flip(flip_q),
		.ctl(cctl), .cos_out(cos_w), .sin_out(sin_w)
	);

	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			ST_MUL_LG: begin ma = 34'($signed(lg_q)); mb = 34'(th_q); end
			ST_MUL_RG: begin ma = 34'($signed(rg_q)); mb = 34'(th_q); end
			ST_MUL_DL: begin ma = 34'(dlc_q); mb = 34'($signed({1'b0, fl_q[23:0]})); end
			ST_MUL_DLH: begin ma = 34'(dlc_q); mb = 34'($signed(fl_q[47:24])); end
			ST_MUL_DR: begin ma = 34'(drc_q); mb = 34'($signed({1'b0, fr_q[23:0]})); end
			ST_MUL_DRH: begin ma = 34'(drc_q); mb = 34'($signed(fr_q[47:24])); end
			ST_MUL_LC: begin ma = dl16_q; mb = c_q; end
			ST_MUL_RS: begin ma = dr16_q; mb = s_q; end
			ST_MUL_LS: begin ma = dl16_q; mb = s_q; end
			ST_MUL_RC: begin ma = dr16_q; mb = c_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cstart = 1'b0;
		unique case (state_q)
			ST_IDLE:    if (s_tvalid) state_d = ST_MUL_LG;
			ST_MUL_LG:  state_d = ST_MUL_RG;
			ST_MUL_RG:  state_d = ST_MUL_DL;
			ST_MUL_DL:  state_d = ST_MUL_DLH;
			ST_MUL_DLH: state_d = ST_MUL_DR;
			ST_MUL_DR:  state_d = ST_MUL_DRH;
			ST_MUL_DRH: state_d = ST_REDUCE;
			ST_REDUCE:  begin cstart = 1'b1; state_d = ST_CORDIC; end
			ST_CORDIC:  if (!cctl.busy) state_d = ST_MUL_LC;
			ST_MUL_LC:  state_d = ST_MUL_RS;
			ST_MUL_RS:  state_d = ST_MUL_LS;
			ST_MUL_LS:  state_d = ST_MUL_RC;
			ST_MUL_RC:  state_d = ST_DONE;
			ST_DONE:    state_d = ST_OUT;
			ST_OUT:     if (m_tready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tdata  = {th_q, y_q, x_q};
	assign m_tvalid = (state_q == ST_OUT);

	// zm_q holds heading*16 plus a multiple of 2*pi, reduced to [0, 2*pi) by
	// two compare-subtract steps per cycle; zr moves it into (-pi, pi]
	always_comb begin
		zr = (zm_q > PI_U) ? 36'(zm_q - TP_U) : 36'(zm_q);
		t_fl = 48'($signed({1'b0, dpc_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q <= '0; lg_q <= '0; rg_q <= '0;
			prev_l_q <= '0; prev_r_q <= '0;
			x_q <= '0; y_q <= '0; th_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIST_PER_COUNT: dpc_q <= cfg_data;
					REG_LEFT_GAIN:      lg_q  <= cfg_data;
					REG_RIGHT_GAIN:     rg_q  <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_IDLE && s_tvalid) begin
				prev_l_q <= s_tdata[15:0];
				prev_r_q <= s_tdata[31:16];
			end
			if (state_q == ST_DONE) begin
				x_q  <= sat(66'(x_q) + 66'(acc_q >>> 30));
				y_q  <= sat(66'(y_q) + 66'(dy_q));
				th_q <= sat(66'(th_q) + 66'((dr_q - dl_q) >>> 5));
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				dlc_q <= 17'($signed(s_tdata[15:0] - prev_l_q));
				drc_q <= 17'($signed(s_tdata[31:16] - prev_r_q));
				zm_q  <= (39'(th_q) << 4) + (th_q[31] ? OFF_U : 39'd0);
			end
			ST_MUL_LG: begin
				fl_q <= t_fl + 48'(prod >>> 16);
				zm_q <= mod_sub(mod_sub(zm_q, OFF_U), TP_U << 4);
			end
			ST_MUL_RG: begin
				fr_q <= t_fl - 48'(prod >>> 16);
				zm_q <= mod_sub(mod_sub(zm_q, TP_U << 3), TP_U << 2);
			end
			ST_MUL_DL: begin
				dl_q <= 64'(prod);
				zm_q <= mod_sub(mod_sub(zm_q, TP_U << 1), TP_U);
			end
			ST_MUL_DLH: dl_q <= dl_q + (64'(prod) <<< 24);
			ST_MUL_DR: dr_q <= 64'(prod);
			ST_MUL_DRH: begin
				dr_q <= dr_q + (64'(prod) <<< 24);
				dl16_q <= clampd(dl_q);
				flip_q <= (zr > Q28_HALF_PI) || (zr < -Q28_HALF_PI);
				z_q <= (zr > Q28_HALF_PI) ? zr - Q28_PI :
					(zr < -Q28_HALF_PI) ? zr + Q28_PI : zr;
			end
			ST_REDUCE: dr16_q <= clampd(dr_q);
			ST_CORDIC: begin c_q <= cos_w; s_q <= sin_w; end
			ST_MUL_LC: acc_q <= 64'(prod);
			ST_MUL_RS: acc_q <= 64'((68'(acc_q) - prod) >>> 30) <<< 30;
			ST_MUL_LS: dy_q <= 64'(prod);
			ST_MUL_RC: dy_q <= 64'((68'(dy_q) + prod) >>> 30);
			default: ;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid && !cctl.busy)
		else $error("input taken while busy");
	a_cordic_start: assert property (@(posedge clk) disable iff (!arst_n)
		cctl.start |=> cctl.busy)
		else $error("cordic did not start");
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the encoder odometry pose update unit.
`timescale 1ns / 100ps

import eopu_pkg::*;

typedef struct {
	logic signed [31:0] x;
	logic signed [31:0] y;
	logic signed [31:0] heading;
} pose_t;

class pose_scoreboard;
	pose_t pending[$];
	int errors;
	logic [31:0] dist_per_count;
	logic signed [31:0] left_gain, right_gain;
	logic [15:0] last_left, last_right;
	logic signed [31:0] x_pos, y_pos, heading;
	longint arctan[32] = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

	function new();
		errors = 0;
		dist_per_count = '0;
		left_gain = '0;
		right_gain = '0;
		last_left = '0;
		last_right = '0;
		x_pos = '0;
		y_pos = '0;
		heading = '0;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_DIST_PER_COUNT: dist_per_count = value;
			REG_LEFT_GAIN:      left_gain = value;
			REG_RIGHT_GAIN:     right_gain = value;
			default: ;
		endcase
	endfunction

	static function longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// rotation-mode CORDIC after folding the angle into [-pi/2, pi/2]
	function void heading_sin_cos(longint th, output longint s, output longint c);
		longint z, cx, cy, xs, ys;
		longint two_pi, pi_q, half_pi;
		bit flip;
		two_pi = Q28_TWO_PI;
		pi_q = Q28_PI;
		half_pi = Q28_HALF_PI;
		z = (th * 16) % two_pi;
		if (z < 0) z += two_pi;
		if (z > pi_q) z -= two_pi;
		flip = 0;
		if (z > half_pi) begin
			z -= pi_q;
			flip = 1;
		end else if (z < -half_pi) begin
			z += pi_q;
			flip = 1;
		end
		cx = CORDIC_GAIN;
		cy = 0;
		for (int i = 0; i < 24; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (z >= 0) begin
				cx -= ys;
				cy += xs;
				z -= arctan[i];
			end else begin
				cx += ys;
				cy -= xs;
				z += arctan[i];
			end
		end
		if (flip) begin
			cx = -cx;
			cy = -cy;
		end
		c = clip(cx, -longint'(Q30_ONE), longint'(Q30_ONE));
		s = clip(cy, -longint'(Q30_ONE), longint'(Q30_ONE));
	endfunction

	function void note_sample(logic [15:0] left_cnt, logic [15:0] right_cnt);
		logic [15:0] dl16b, dr16b;
		longint dlc, drc, th, fl, fr, dl, dr, dl16, dr16, s, c, lim;
		pose_t p;
		dl16b = left_cnt - last_left;
		dr16b = right_cnt - last_right;
		dlc = longint'($signed(dl16b));
		drc = longint'($signed(dr16b));
		last_left = left_cnt;
		last_right = right_cnt;
		th = heading;
		fl = longint'({1'b0, dist_per_count}) + ((longint'(left_gain) * th) >>> 16);
		fr = longint'({1'b0, dist_per_count}) - ((longint'(right_gain) * th) >>> 16);
		dl = dlc * fl;
		dr = drc * fr;
		heading_sin_cos(th, s, c);
		lim = DIST_LIMIT;
		dl16 = clip(dl >>> 16, -lim, lim);
		dr16 = clip(dr >>> 16, -lim, lim);
		x_pos = clip(longint'(x_pos) + ((dl16 * c - dr16 * s) >>> 30), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		y_pos = clip(longint'(y_pos) + ((dl16 * s + dr16 * c) >>> 30), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		heading = clip(th + ((dr - dl) >>> 5), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
		p.x = x_pos;
		p.y = y_pos;
		p.heading = heading;
		pending.push_back(p);
	endfunction

	function void check_pose(logic [95:0] data);
		pose_t p;
		if (pending.size() == 0) begin
			$error("pose transfer with nothing expected: %h", data);
			errors++;
			return;
		end
		p = pending.pop_front();
		if (data[31:0] !== p.x) begin
			$error("x_out: expected %0d, got %0d", p.x, $signed(data[31:0]));
			errors++;
		end
		if (data[63:32] !== p.y) begin
			$error("y_out: expected %0d, got %0d", p.y, $signed(data[63:32]));
			errors++;
		end
		if (data[95:64] !== p.heading) begin
			$error("heading_out: expected %0d, got %0d", p.heading, $signed(data[95:64]));
			errors++;
		end
	endfunction
endclass

module tb;
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int ITEMS_PER_PHASE = 275;

	logic clk, arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [31:0] s_tdata;
	logic [95:0] m_tdata;

	pose_scoreboard sb = new();
	int send_idle_pct, recv_stall_pct;
	int cycles;
	logic [15:0] cur_left, cur_right;

	encoder_odometry_pose_update_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_pose(m_tdata);
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = value;
		sb.write_reg(idx, value);
		@(negedge clk);
		cfg_we = 0;
	endtask

	// called at a falling edge; returns at a falling edge
	task automatic send_sample(logic [15:0] l, logic [15:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 0;
			@(negedge clk);
		end
		s_tvalid = 1;
		s_tdata = {r, l};
		do @(posedge clk); while (!s_tready);
		sb.note_sample(l, r);
		cur_left = l;
		cur_right = r;
		@(negedge clk);
	endtask

	task automatic drain();
		s_tvalid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic random_sample();
		int span;
		span = $urandom_range(3) == 0 ? 32767 : ($urandom_range(1) ? 40 : 600);
		if ($urandom_range(9) == 0)
			send_sample(16'($urandom), 16'($urandom));
		else
			send_sample(cur_left + 16'($urandom_range(2 * span) - span),
				cur_right + 16'($urandom_range(2 * span) - span));
	endtask

	initial begin
		logic [31:0] dist_set[6];
		logic [31:0] lg_set[6];
		logic [31:0] rg_set[6];
		cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cur_left = '0;
		cur_right = '0;
		dist_set = '{32'h0010_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0004_0000,
			32'h0000_0001, $urandom};
		lg_set = '{32'h0000_1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_F000,
			32'h0000_0000, $urandom};
		rg_set = '{32'hFFFF_E000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_2000,
			32'h0000_0000, $urandom};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_DIST_PER_COUNT, dist_set[ph]);
			write_reg(REG_LEFT_GAIN, lg_set[ph]);
			write_reg(REG_RIGHT_GAIN, rg_set[ph]);
			if (ph == 2) write_reg(REG_UNUSED, 32'hDEAD_BEEF);
			if (ph == 0) begin
				// extreme counts, wrap-around deltas, no motion, pure turns
				send_sample(16'h0000, 16'h0000);
				send_sample(16'h7FFF, 16'h7FFF);
				send_sample(16'h8000, 16'h8000);
				send_sample(16'hFFFF, 16'h0000);
				send_sample(16'h0001, 16'hFFFF);
				send_sample(16'h0001, 16'hFFFF);
				send_sample(16'h0101, 16'hFEFF);
				send_sample(16'h0001, 16'h00FF);
				send_sample(16'h7FFF, 16'h8000);
				send_sample(16'h5555, 16'hAAAA);
				send_sample(16'hAAAA, 16'h5555);
				send_sample(16'h0000, 16'h0000);
				for (int k = 0; k < 10; k++)
					send_sample(cur_left + 16'd300, cur_right - 16'd300);
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ((n / 70 + ph) % 4)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
					default: begin send_idle_pct = 16; recv_stall_pct = 16; end
				endcase
				if (ph == 3 && n == 100) drain();
				random_sample();
			end
		end

		s_tvalid = 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (sb.errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
